>>> design/tfce_pkg.sv
// Shared types and constants for the telemetry frame CRC check and field extract unit.
// No dependencies; every other design file but tfce_ifs imports this package.
package tfce_pkg;

    // Frame layout
    localparam int POS_W       = 7;
    localparam int FRAME_BYTES = 74;
    localparam int CRC_SPAN    = 70;
    localparam int POS_CRC_LO  = CRC_SPAN + 1;
    localparam int POS_CRC_HI  = CRC_SPAN + 2;

    // CRC-16, reflected form
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Captured items
    localparam int ITEM_COUNT = 13;
    localparam int ID_W       = 4;
    localparam logic [7:0] NO_BYTE = 8'hFF;

    // Byte offset of the low (or only) byte and of the high byte for each item
    localparam logic [7:0] ITEM_LO [ITEM_COUNT] =
        '{8'd40, 8'd7, 8'd9, 8'd21, 8'd27, 8'd23, 8'd25, 8'd19, 8'd58, 8'd34,
          8'd67, 8'd68, 8'd37};
    localparam logic [7:0] ITEM_HI [ITEM_COUNT] =
        '{NO_BYTE, 8'd8, 8'd10, 8'd22, 8'd28, 8'd24, 8'd26, 8'd20, 8'd59, 8'd35,
          NO_BYTE, NO_BYTE, NO_BYTE};

    // One checked frame, as handed from the front part to the result sequencer
    typedef struct packed {
        logic [ITEM_COUNT-1:0][15:0] values;
        logic                        good;
        logic [15:0]                 crc;
    } frame_rec_t;

endpackage

>>> design/tfce_ifs.sv
// Valid/ready channel interfaces for the byte input and the result output.
// No dependencies.
interface tfce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, rx_byte, frame_start, input ready);
    modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface tfce_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  item_id;
    logic [15:0] item_value;
    logic        crc_good;
    logic        last;

    modport source (output valid, item_id, item_value, crc_good, last, input ready);
    modport sink   (input valid, item_id, item_value, crc_good, last, output ready);
endinterface

>>> design/tfce_front.sv
// Front part: tracks the byte position, runs the CRC, captures item fields.
// Depends on tfce_pkg; pushes one frame record per checked frame.
module tfce_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  logic                frame_start,
    input  logic                q_full,
    output logic                push_valid,
    output tfce_pkg::frame_rec_t push_data
);
    import tfce_pkg::*;

    logic [POS_W-1:0]            pos_reg, pos_next, pos_eff;
    logic [15:0]                 crc_reg, crc_next;
    logic [7:0]                  crc_lo_reg, crc_lo_next;
    logic [ITEM_COUNT-1:0][15:0] cap_reg, cap_next;
    logic                        accept;

    // One byte of the reflected CRC, bit by bit
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Stall only when no queue slot is free
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign pos_eff  = frame_start ? '0 : pos_reg;

    // Advance position, CRC and captures
    always_comb
    begin
        pos_next    = (pos_eff == POS_W'(FRAME_BYTES - 1)) ? '0 : pos_eff + 1'b1;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        cap_next    = cap_reg;
        if (pos_eff == '0)
            crc_next = CRC_INIT;
        else if (pos_eff <= POS_W'(CRC_SPAN))
            crc_next = crc_byte(crc_reg, rx_byte);
        if (pos_eff == POS_W'(POS_CRC_LO))
            crc_lo_next = rx_byte;
        for (int i = 0; i < ITEM_COUNT; i++)
        begin
            if ({1'b0, pos_eff} == ITEM_LO[i])
            begin
                if (ITEM_HI[i] == NO_BYTE)
                    cap_next[i] = {8'h00, rx_byte};
                else
                    cap_next[i][7:0] = rx_byte;
            end
            else if ({1'b0, pos_eff} == ITEM_HI[i])
                cap_next[i][15:8] = rx_byte;
        end
    end

    // Hand off the frame when the high CRC byte arrives
    assign push_valid       = accept && (pos_eff == POS_W'(POS_CRC_HI));
    assign push_data.values = cap_reg;
    assign push_data.crc    = crc_reg;
    assign push_data.good   = (crc_lo_reg == crc_reg[7:0]) && (rx_byte == crc_reg[15:8]);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= CRC_INIT;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    // Captured payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            crc_lo_reg <= crc_lo_next;
            cap_reg    <= cap_next;
        end
    end

endmodule

>>> design/tfce_queue.sv
// Two-entry queue of frame records between the front part and the sequencer.
// Depends on tfce_pkg.
module tfce_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  tfce_pkg::frame_rec_t push_data,
    output logic                 full,
    output logic                 head_valid,
    output tfce_pkg::frame_rec_t head_data,
    input  logic                 pop
);
    import tfce_pkg::*;

    frame_rec_t  slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = slot_reg[rd_ptr_reg];

    // Move pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push_valid ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push_valid)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the record
    always_ff @(posedge clk)
    begin
        if (push_valid)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> design/tfce_back.sv
// Back part: walks the head frame record and emits one result per cycle unless the output stalls.
// Depends on tfce_pkg; drives a registered output stage.
module tfce_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  tfce_pkg::frame_rec_t head_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           item_id,
    output logic [15:0]          item_value,
    output logic                 crc_good,
    output logic                 last
);
    import tfce_pkg::*;

    logic [ID_W-1:0] idx_reg, idx_next;
    logic            valid_reg, valid_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [15:0]     value_reg, value_next;
    logic            good_reg, good_next;
    logic            last_reg, last_next;
    logic            emit;

    // Load the output register when it is empty or being drained
    assign emit = head_valid && (!valid_reg || out_ready);

    // Select the next result
    always_comb
    begin
        id_next    = id_reg;
        value_next = value_reg;
        good_next  = good_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        if (emit)
        begin
            good_next = head_data.good;
            if (head_data.good)
            begin
                id_next    = idx_reg;
                value_next = head_data.values[idx_reg];
                last_next  = (idx_reg == ID_W'(ITEM_COUNT - 1));
            end
            else
            begin
                id_next    = '0;
                value_next = head_data.crc;
                last_next  = 1'b1;
            end
            if (last_next)
            begin
                pop      = 1'b1;
                idx_next = '0;
            end
            else
                idx_next = idx_reg + 1'b1;
        end
        valid_next = emit || (valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        value_reg <= value_next;
        good_reg  <= good_next;
        last_reg  <= last_next;
    end

    assign out_valid  = valid_reg;
    assign item_id    = id_reg;
    assign item_value = value_reg;
    assign crc_good   = good_reg;
    assign last       = last_reg;

endmodule

>>> design/telemetry_frame_crc_field_extract_unit.sv
// Top level of the telemetry frame CRC check and field extract unit.
// Depends on tfce_pkg, tfce_ifs, tfce_front, tfce_queue and tfce_back.
//
// The unit takes one frame byte per cycle on rx, runs a reflected CRC-16 (init 0xFFFF,
// poly 0xA001) over bytes 1 to 70 and checks it against bytes 71 (low) and 72 (high) of a
// 74-byte frame; frame_start forces the byte to be byte 0. When byte 72 is taken, a frame
// record goes into a two-entry queue; the result sequencer then emits from an output register,
// one per cycle while tx.ready is high, either thirteen captured values (crc_good 1, last on
// the thirteenth) or a single error result carrying the computed CRC. Input runs at one byte
// per cycle and stalls only while both queue entries hold frames, i.e. when the result side
// has been held back for a full frame or more.
module telemetry_frame_crc_field_extract_unit (
    input  logic        clk,
    input  logic        rst_n,
    tfce_in_if.sink     rx,
    tfce_out_if.source  tx
);
    import tfce_pkg::*;

    logic       q_full;
    logic       push_valid;
    frame_rec_t push_data;
    logic       head_valid;
    frame_rec_t head_data;
    logic       pop;

    // Byte intake, CRC and capture
    tfce_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (rx.valid),
        .in_ready    (rx.ready),
        .rx_byte     (rx.rx_byte),
        .frame_start (rx.frame_start),
        .q_full      (q_full),
        .push_valid  (push_valid),
        .push_data   (push_data)
    );

    // Frame record queue
    tfce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    // Result sequencer
    tfce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (tx.valid),
        .out_ready  (tx.ready),
        .item_id    (tx.item_id),
        .item_value (tx.item_value),
        .crc_good   (tx.crc_good),
        .last       (tx.last)
    );

endmodule

>>> tb/tb_telemetry_frame_crc_field_extract_unit.sv
// Testbench for telemetry_frame_crc_field_extract_unit: streams whole, broken and wrapped
// frames, predicts the per-frame results and checks each result request field by field.
// Depends on tfce_pkg, tfce_ifs and the design files of the unit.
`timescale 1ns / 100ps

module tb_telemetry_frame_crc_field_extract_unit;

    localparam int          FRAME_LEN = 74;
    localparam int          CRC_LAST  = 70;
    localparam logic [15:0] CRC_SEED  = 16'hFFFF;
    localparam logic [15:0] CRC_TAPS  = 16'hA001;
    localparam int          NUM_ITEMS = 13;
    localparam logic [7:0]  NO_OFS    = 8'hFF;
    localparam int          HOLD_CYCLES = 600;
    localparam int          PRINT_CAP   = 40;

    // Byte offsets per item, item 0 in the low slot
    localparam logic [NUM_ITEMS-1:0][7:0] LO_OFS =
        {8'd37, 8'd68, 8'd67, 8'd34, 8'd58, 8'd19, 8'd25, 8'd23, 8'd27, 8'd21, 8'd9,
         8'd7, 8'd40};
    localparam logic [NUM_ITEMS-1:0][7:0] HI_OFS =
        {NO_OFS, NO_OFS, NO_OFS, 8'd35, 8'd59, 8'd20, 8'd26, 8'd24, 8'd28, 8'd22, 8'd10,
         8'd8, NO_OFS};

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_MIXED} fill_t;
    typedef enum int {DMG_NONE, DMG_CRC_LO, DMG_CRC_HI, DMG_BODY} damage_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } byte_req_t;

    typedef struct packed {
        logic [3:0]  id;
        logic [15:0] value;
        logic        good;
        logic        last;
    } item_result_t;

    logic clk;
    logic rst_n;

    tfce_in_if  rx_ch ();
    tfce_out_if tx_ch ();

    telemetry_frame_crc_field_extract_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    byte_req_t    byte_reqs [$];
    item_result_t due_results [$];

    // Frame tracker state
    logic [6:0]            trk_pos;
    logic [15:0]           trk_crc;
    logic [15:0]           trk_vals [NUM_ITEMS];
    logic [7:0]            trk_crc_lo;

    int  mismatches;
    int  bytes_taken;
    bit  offer_open;
    int  burst_left;
    int  gap_left;
    bit  hold_off;
    int  seg_left;
    int  seg_mode;
    bit  alt_phase;

    // Fold one byte into a reflected CRC-16
    function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        int k;
        begin
            c = acc ^ {8'h00, b};
            for (k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ CRC_TAPS) : (c >> 1);
            return c;
        end
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        begin
            if (mismatches < PRINT_CAP)
                $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
            mismatches++;
        end
    endtask

    // Advance the frame tracker by one accepted byte and queue any results it causes
    task automatic track_frame_byte(input logic [7:0] b, input logic start);
        logic [6:0]   p;
        item_result_t r;
        int           i;
        begin
            if (start)
                trk_pos = '0;
            p = trk_pos;

            if (p == 0)
                trk_crc = CRC_SEED;
            else if (p <= CRC_LAST)
                trk_crc = crc16_fold(trk_crc, b);

            for (i = 0; i < NUM_ITEMS; i++)
            begin
                if ({1'b0, p} == LO_OFS[i])
                begin
                    if (HI_OFS[i] == NO_OFS)
                        trk_vals[i] = {8'h00, b};
                    else
                        trk_vals[i][7:0] = b;
                end
                else if ({1'b0, p} == HI_OFS[i])
                    trk_vals[i][15:8] = b;
            end

            if (p == CRC_LAST + 1)
                trk_crc_lo = b;
            else if (p == CRC_LAST + 2)
            begin
                if ({b, trk_crc_lo} == trk_crc)
                begin
                    for (i = 0; i < NUM_ITEMS; i++)
                    begin
                        r.id    = i[3:0];
                        r.value = trk_vals[i];
                        r.good  = 1'b1;
                        r.last  = (i == NUM_ITEMS - 1);
                        due_results.push_back(r);
                    end
                end
                else
                begin
                    r.id    = 4'd0;
                    r.value = trk_crc;
                    r.good  = 1'b0;
                    r.last  = 1'b1;
                    due_results.push_back(r);
                end
            end

            if (p == FRAME_LEN - 1)
                trk_pos = '0;
            else
                trk_pos = p + 7'd1;
        end
    endtask

    // Build one frame with a correct CRC, damage it if asked and queue its first bytes
    task automatic queue_frame(input fill_t fill, input bit with_start, input damage_t dmg,
                               input int keep);
        logic [7:0]  fr [FRAME_LEN];
        logic [15:0] c;
        byte_req_t   r;
        int          k;
        begin
            for (k = 0; k < FRAME_LEN; k++)
            begin
                case (fill)
                    FILL_ZERO:  fr[k] = 8'h00;
                    FILL_ONES:  fr[k] = 8'hFF;
                    FILL_MIXED:
                        case ($urandom_range(0, 3))
                            0:       fr[k] = 8'h00;
                            1:       fr[k] = 8'hFF;
                            default: fr[k] = 8'($urandom_range(0, 255));
                        endcase
                    default:    fr[k] = 8'($urandom_range(0, 255));
                endcase
            end
            c = CRC_SEED;
            for (k = 1; k <= CRC_LAST; k++)
                c = crc16_fold(c, fr[k]);
            fr[CRC_LAST + 1] = c[7:0];
            fr[CRC_LAST + 2] = c[15:8];

            case (dmg)
                DMG_CRC_LO: fr[CRC_LAST + 1] ^= 8'h01 << $urandom_range(0, 7);
                DMG_CRC_HI: fr[CRC_LAST + 2] ^= 8'h01 << $urandom_range(0, 7);
                DMG_BODY:   fr[$urandom_range(1, CRC_LAST)] ^= 8'($urandom_range(1, 255));
                default:    ;
            endcase

            for (k = 0; k < keep; k++)
            begin
                r.data  = fr[k];
                r.start = (k == 0) ? with_start : 1'b0;
                byte_reqs.push_back(r);
            end
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Take byte requests at the rising edge and feed the tracker
    always @(posedge clk)
    begin
        if (rst_n && rx_ch.valid && rx_ch.ready)
        begin
            track_frame_byte(rx_ch.rx_byte, rx_ch.frame_start);
            void'(byte_reqs.pop_front());
            bytes_taken++;
            offer_open = 1'b0;
        end
    end

    // Offer byte requests in bursts with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            rx_ch.valid <= 1'b0;
        else if (!offer_open)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                rx_ch.valid <= 1'b0;
            end
            else if (byte_reqs.size() != 0)
            begin
                rx_ch.valid       <= 1'b1;
                rx_ch.rx_byte     <= byte_reqs[0].data;
                rx_ch.frame_start <= byte_reqs[0].start;
                offer_open = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                rx_ch.valid <= 1'b0;
        end
    end

    // Drive result ready from segments of changing stall patterns
    always @(negedge clk)
    begin
        if (!rst_n)
            tx_ch.ready <= 1'b0;
        else
        begin
            if (seg_left <= 0)
            begin
                seg_mode = $urandom_range(0, 3);
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            alt_phase = ~alt_phase;
            case (seg_mode)
                0:       tx_ch.ready <= !hold_off;
                1:       tx_ch.ready <= !hold_off && alt_phase;
                2:       tx_ch.ready <= !hold_off && ($urandom_range(0, 3) != 0);
                default: tx_ch.ready <= !hold_off && ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // Hold the result side off for a long stretch once traffic is under way
    initial
    begin
        int n;
        hold_off = 1'b0;
        while (bytes_taken < 100)
            @(posedge clk);
        hold_off = 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++)
            @(posedge clk);
        hold_off = 1'b0;
    end

    // Check every result request against the oldest expected one
    always @(posedge clk)
    begin
        item_result_t want;
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            if (due_results.size() == 0)
                note_mismatch("unexpected result, item_id", tx_ch.item_id, 0);
            else
            begin
                want = due_results.pop_front();
                if (tx_ch.item_id !== want.id)
                    note_mismatch("item_id", tx_ch.item_id, want.id);
                if (tx_ch.item_value !== want.value)
                    note_mismatch("item_value", tx_ch.item_value, want.value);
                if (tx_ch.crc_good !== want.good)
                    note_mismatch("crc_good", tx_ch.crc_good, want.good);
                if (tx_ch.last !== want.last)
                    note_mismatch("last", tx_ch.last, want.last);
            end
        end
    end

    // Stop a hung run
    initial
    begin
        #2400000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int  pick;
        int  n;
        int  k;
        bit  at_edge;

        rst_n             = 1'b0;
        rx_ch.valid       = 1'b0;
        rx_ch.rx_byte     = 8'h00;
        rx_ch.frame_start = 1'b0;
        tx_ch.ready       = 1'b0;
        mismatches  = 0;
        bytes_taken = 0;
        offer_open  = 1'b0;
        burst_left  = 0;
        gap_left    = 0;
        seg_left    = 0;
        seg_mode    = 0;
        alt_phase   = 1'b0;
        trk_pos     = '0;
        trk_crc     = CRC_SEED;
        trk_crc_lo  = 8'h00;
        for (k = 0; k < NUM_ITEMS; k++)
            trk_vals[k] = 16'h0000;

        // Directed frames: field extremes, wrap into a new frame, bad CRC halves,
        // a frame cut short by frame_start
        queue_frame(FILL_ZERO, 1'b1, DMG_NONE, FRAME_LEN);
        queue_frame(FILL_ONES, 1'b1, DMG_NONE, FRAME_LEN);
        queue_frame(FILL_MIXED, 1'b0, DMG_NONE, FRAME_LEN);
        queue_frame(FILL_RANDOM, 1'b1, DMG_CRC_HI, FRAME_LEN);
        queue_frame(FILL_RANDOM, 1'b0, DMG_CRC_LO, FRAME_LEN);
        queue_frame(FILL_RANDOM, 1'b1, DMG_NONE, 30);

        // Random part: mostly well-formed frames, some damaged, cut short or noise
        at_edge = 1'b0;
        while (byte_reqs.size() < 450)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
            begin
                queue_frame(($urandom_range(0, 4) == 0) ? FILL_MIXED : FILL_RANDOM, 1'b1,
                            DMG_NONE, FRAME_LEN);
                at_edge = 1'b1;
            end
            else if (pick < 70)
            begin
                queue_frame(FILL_RANDOM, !at_edge, DMG_NONE, FRAME_LEN);
                at_edge = 1'b1;
            end
            else if (pick < 80)
            begin
                queue_frame(FILL_RANDOM, 1'b1, damage_t'($urandom_range(1, 3)), FRAME_LEN);
                at_edge = 1'b1;
            end
            else if (pick < 90)
            begin
                queue_frame(FILL_RANDOM, 1'b1, DMG_NONE, $urandom_range(1, FRAME_LEN - 1));
                at_edge = 1'b0;
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++)
                    byte_reqs.push_back({8'($urandom_range(0, 255)),
                                         1'($urandom_range(0, 7) == 0)});
                at_edge = 1'b0;
            end
        end

        // Reset
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain input and results, then allow for late strays
        while (byte_reqs.size() != 0 || offer_open || due_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
